// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/ptt_pkg.sv =====
package ptt_pkg;

  // slot index is the low key bits
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned PlyLimit     = 255;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned PlyW  = 8;
  localparam int unsigned MoveW = 32;

  typedef enum logic [1:0] {
    CmdLookup    = 2'd0,
    CmdProven    = 2'd1,
    CmdDisproven = 2'd2
  } cmd_e;

  typedef struct packed {
    logic            proven;
    logic [PlyW-1:0] plen;
    logic            disproven;
    logic [PlyW-1:0] ddepth;
    logic            has_move;
  } status_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] tag;
    status_t         status;
  } meta_t;

  typedef struct packed {
    logic             hit;
    logic             is_proven;
    logic [PlyW-1:0]  proven_length;
    logic             is_disproven;
    logic [PlyW-1:0]  disproven_depth;
    logic             move_valid;
    logic [MoveW-1:0] stored_move;
  } res_t;

endpackage

// ===== hw/rtl/ptt_update.sv =====
module ptt_update #(
  parameter int MOVE_W = 32
) (
  input  logic [1:0]                cmd_i,
  input  logic [ptt_pkg::KeyW-1:0]  key_i,
  input  logic [ptt_pkg::PlyW-1:0]  ply_i,
  input  logic [MOVE_W-1:0]         move_i,
  input  ptt_pkg::meta_t            old_meta_i,
  input  logic [MOVE_W-1:0]         old_move_i,
  output ptt_pkg::meta_t            new_meta_o,
  output logic [MOVE_W-1:0]         new_move_o,
  output ptt_pkg::res_t             result_o
);
  import ptt_pkg::*;

  logic [PlyW-1:0]  ply_sat;
  logic             tag_match;
  logic             is_store;
  meta_t            base;
  logic [MoveW-1:0] move_ext;

  always_comb begin
    if ({8'd0, ply_i} > 16'(PlyLimit)) begin
      ply_sat = PlyW'(PlyLimit);
    end else begin
      ply_sat = ply_i;
    end
  end

  assign tag_match = old_meta_i.valid && (old_meta_i.tag == key_i);

  always_comb begin
    // a store to a foreign or empty slot starts from a fresh entry
    if (tag_match) begin
      base = old_meta_i;
    end else begin
      base       = '0;
      base.valid = 1'b1;
      base.tag   = key_i;
    end
    new_meta_o = old_meta_i;
    new_move_o = old_move_i;
    is_store   = 1'b0;
    unique case (cmd_e'(cmd_i))
      CmdProven: begin
        is_store   = 1'b1;
        new_meta_o = base;
        if (!(base.status.proven && base.status.plen <= ply_sat)) begin
          new_meta_o.status.proven   = 1'b1;
          new_meta_o.status.plen     = ply_sat;
          new_meta_o.status.has_move = (ply_sat != '0);
          if (ply_sat != '0) begin
            new_move_o = move_i;
          end
        end
      end
      CmdDisproven: begin
        is_store   = 1'b1;
        new_meta_o = base;
        if (!base.status.disproven || ply_sat > base.status.ddepth) begin
          new_meta_o.status.disproven = 1'b1;
          new_meta_o.status.ddepth    = ply_sat;
        end
      end
      default: begin
        is_store = 1'b0;
      end
    endcase
  end

  if (MOVE_W < MoveW) begin : g_move_ext
    assign move_ext = {{(MoveW - MOVE_W){1'b0}}, new_move_o};
  end else begin : g_move_full
    assign move_ext = new_move_o[MoveW-1:0];
  end

  always_comb begin
    result_o     = '0;
    result_o.hit = is_store || tag_match;
    if (result_o.hit) begin
      result_o.is_proven       = new_meta_o.status.proven;
      result_o.proven_length   = new_meta_o.status.proven ? new_meta_o.status.plen : '0;
      result_o.is_disproven    = new_meta_o.status.disproven;
      result_o.disproven_depth =
          new_meta_o.status.disproven ? new_meta_o.status.ddepth : '0;
      result_o.move_valid      = new_meta_o.status.has_move;
      result_o.stored_move     = new_meta_o.status.has_move ? move_ext : '0;
    end
  end

endmodule

// ===== hw/rtl/proof_transposition_table.sv =====
// direct-mapped transposition table for a proof search
// input stream: s_axis_tuser carries the command (lookup, store proven,
// store disproven; the unused code acts as a lookup), s_axis_tdata the key,
// the ply and the first move. each request gives exactly one result on the
// output stream: hit flag plus the slot contents after the command.
// timing: an accepted request is registered into the update stage, and its
// result is registered into the output register when the update stage moves
// on; the table takes one request per cycle while the receiver keeps up. the
// slot memory is read on acceptance and written back when the request leaves
// the update stage, and a request accepted while its slot is being written
// takes the new value from a forwarding register.
// reset: a clearing pass sweeps the 1024 slots, one per cycle, so
// s_axis_tready stays low until the pass is over after reset is released.
// when the receiver stalls, one result waits in the output register and the
// request behind it stays in the update stage; new requests are held off
// until the output register frees up.
module proof_transposition_table #(
  parameter int MOVE_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position_key[63:0], ply[71:64], first_move[103:72]
  input  logic [103:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], is_proven[1], proven_length[9:2], is_disproven[10],
  // disproven_depth[18:11], move_valid[19], stored_move[51:20], zero[55:52]
  output logic [55:0]  m_axis_tdata
);
  import ptt_pkg::*;

  `include "assert_macros.svh"

  localparam int MoveBits = (MOVE_BITS < 32) ? MOVE_BITS : 32;

  meta_t                meta_mem [TableEntries];
  logic [MoveBits-1:0]  move_mem [TableEntries];

  logic                 clearing_q;
  logic [IdxW-1:0]      clr_q;

  logic                 in_acc;
  logic [IdxW-1:0]      in_idx;

  logic                 s1_valid_q;
  logic [1:0]           s1_cmd_q;
  logic [KeyW-1:0]      s1_key_q;
  logic [PlyW-1:0]      s1_ply_q;
  logic [MoveBits-1:0]  s1_move_q;
  logic [IdxW-1:0]      s1_idx;
  logic                 s1_adv;
  logic                 s1_fire;

  meta_t                rd_meta_q;
  logic [MoveBits-1:0]  rd_move_q;
  logic                 fwd_q;
  meta_t                fwd_meta_q;
  logic [MoveBits-1:0]  fwd_move_q;

  meta_t                old_meta;
  logic [MoveBits-1:0]  old_move;
  meta_t                new_meta;
  logic [MoveBits-1:0]  new_move;
  res_t                 result;

  logic                 out_valid_q;
  res_t                 out_q;

  assign in_idx  = s_axis_tdata[IdxW-1:0];
  assign s1_idx  = s1_key_q[IdxW-1:0];
  assign s1_adv  = !out_valid_q || m_axis_tready;
  assign s1_fire = s1_valid_q && s1_adv;

  assign s_axis_tready = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // clearing pass over the slot metadata
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == IdxW'(TableEntries - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      meta_mem[clr_q] <= '0;
    end else if (s1_fire) begin
      meta_mem[s1_idx] <= new_meta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      move_mem[s1_idx] <= new_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_meta_q  <= meta_mem[in_idx];
      rd_move_q  <= move_mem[in_idx];
      fwd_meta_q <= new_meta;
      fwd_move_q <= new_move;
      s1_cmd_q   <= s_axis_tuser;
      s1_key_q   <= s_axis_tdata[63:0];
      s1_ply_q   <= s_axis_tdata[71:64];
      s1_move_q  <= s_axis_tdata[72 +: MoveBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      // the slot written this cycle is read stale by the memory
      fwd_q      <= s1_valid_q && (s1_idx == in_idx);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  assign old_meta = fwd_q ? fwd_meta_q : rd_meta_q;
  assign old_move = fwd_q ? fwd_move_q : rd_move_q;

  ptt_update #(
    .MOVE_W (MoveBits)
  ) u_update (
    .cmd_i      (s1_cmd_q),
    .key_i      (s1_key_q),
    .ply_i      (s1_ply_q),
    .move_i     (s1_move_q),
    .old_meta_i (old_meta),
    .old_move_i (old_move),
    .new_meta_o (new_meta),
    .new_move_o (new_move),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.stored_move, out_q.move_valid, out_q.disproven_depth,
                          out_q.is_disproven, out_q.proven_length, out_q.is_proven,
                          out_q.hit};

  `ASSERT_CLK(a_clear_once, !clearing_q |=> !clearing_q, "clearing pass restarted")
  `ASSERT_CLK(a_idle_while_clear, clearing_q |-> !s1_valid_q && !out_valid_q,
              "request in flight during clearing pass")
  `ASSERT_CLK(a_store_hits, s1_fire && (s1_cmd_q == CmdProven || s1_cmd_q == CmdDisproven)
              |=> out_q.hit, "store result without hit")
  `ASSERT_CLK(a_move_needs_len, out_valid_q && out_q.move_valid
              |-> out_q.is_proven && out_q.proven_length != '0,
              "best move without proven length")

endmodule

// ===== test/ptt_checker.sv =====
`timescale 1ns / 1ps
module ptt_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // position_key[63:0], ply[71:64], first_move[103:72]
  input  logic [103:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], is_proven[1], proven_length[9:2], is_disproven[10],
  // disproven_depth[18:11], move_valid[19], stored_move[51:20], zero[55:52]
  input  logic [55:0]  m_axis_tdata,
  output int           mismatch_count_o,
  output int           outstanding_o
);
  import ptt_pkg::*;

  // shadow copy of the table
  logic             slot_used      [TableEntries];
  logic [KeyW-1:0]  slot_key       [TableEntries];
  status_t          slot_state     [TableEntries];
  logic [MoveW-1:0] slot_best_move [TableEntries];

  // slot contents expected back, oldest request first
  res_t slot_reply_q[$];

  int   mismatches;
  res_t want;
  res_t got;

  task automatic report_mismatch(input string what, input logic [63:0] got_val,
                                 input logic [63:0] want_val);
    $display("%0t ptt_checker: %s got %0h want %0h", $time, what, got_val, want_val);
    mismatches++;
  endtask

  function automatic res_t apply_command(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                                         input logic [PlyW-1:0] ply_in,
                                         input logic [MoveW-1:0] mv);
    logic [IdxW-1:0] idx;
    logic [PlyW-1:0] ply;
    res_t            r;
    idx = key[IdxW-1:0];
    ply = (ply_in > PlyLimit) ? PlyW'(PlyLimit) : ply_in;
    if (cmd == CmdProven || cmd == CmdDisproven) begin
      // a store to an empty or foreign slot starts from a clean entry
      if (!slot_used[idx] || slot_key[idx] != key) begin
        slot_used[idx]      = 1'b1;
        slot_key[idx]       = key;
        slot_state[idx]     = '0;
        slot_best_move[idx] = '0;
      end
    end
    if (cmd == CmdProven) begin
      if (!(slot_state[idx].proven && slot_state[idx].plen <= ply)) begin
        slot_state[idx].proven   = 1'b1;
        slot_state[idx].plen     = ply;
        slot_state[idx].has_move = (ply != '0);
        if (ply != '0) begin
          slot_best_move[idx] = mv;
        end
      end
    end else if (cmd == CmdDisproven) begin
      if (!slot_state[idx].disproven || ply > slot_state[idx].ddepth) begin
        slot_state[idx].disproven = 1'b1;
        slot_state[idx].ddepth    = ply;
      end
    end
    r = '0;
    if (slot_used[idx] && slot_key[idx] == key) begin
      r.hit             = 1'b1;
      r.is_proven       = slot_state[idx].proven;
      r.proven_length   = slot_state[idx].proven ? slot_state[idx].plen : '0;
      r.is_disproven    = slot_state[idx].disproven;
      r.disproven_depth = slot_state[idx].disproven ? slot_state[idx].ddepth : '0;
      r.move_valid      = slot_state[idx].has_move;
      r.stored_move     = slot_state[idx].has_move ? slot_best_move[idx] : '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      slot_reply_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (m_axis_tvalid && m_axis_tready) begin
        if (slot_reply_q.size() == 0) begin
          report_mismatch("result with no request", 64'(m_axis_tdata), '0);
        end else begin
          want                = slot_reply_q.pop_front();
          got.hit             = m_axis_tdata[0];
          got.is_proven       = m_axis_tdata[1];
          got.proven_length   = m_axis_tdata[9:2];
          got.is_disproven    = m_axis_tdata[10];
          got.disproven_depth = m_axis_tdata[18:11];
          got.move_valid      = m_axis_tdata[19];
          got.stored_move     = m_axis_tdata[51:20];
          if (got.hit !== want.hit)
            report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.is_proven !== want.is_proven)
            report_mismatch("is_proven", 64'(got.is_proven), 64'(want.is_proven));
          if (got.proven_length !== want.proven_length)
            report_mismatch("proven_length", 64'(got.proven_length),
                            64'(want.proven_length));
          if (got.is_disproven !== want.is_disproven)
            report_mismatch("is_disproven", 64'(got.is_disproven), 64'(want.is_disproven));
          if (got.disproven_depth !== want.disproven_depth)
            report_mismatch("disproven_depth", 64'(got.disproven_depth),
                            64'(want.disproven_depth));
          if (got.move_valid !== want.move_valid)
            report_mismatch("move_valid", 64'(got.move_valid), 64'(want.move_valid));
          if (got.stored_move !== want.stored_move)
            report_mismatch("stored_move", 64'(got.stored_move), 64'(want.stored_move));
          if (m_axis_tdata[55:52] !== 4'd0)
            report_mismatch("padding", 64'(m_axis_tdata[55:52]), '0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        slot_reply_q.push_back(apply_command(s_axis_tuser, s_axis_tdata[63:0],
                                             s_axis_tdata[71:64], s_axis_tdata[103:72]));
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= slot_reply_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ptt_pkg::*;

  localparam logic [1:0]  CmdSpare    = 2'd3;
  localparam int unsigned PhaseItems  = 584;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PoolSize    = 32;
  localparam int unsigned PoolSlots   = 8;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;

  int           mismatch_count;
  int           outstanding;
  int unsigned  send_idle_pct  = 18;
  int unsigned  recv_stall_pct = 54;
  int unsigned  quiet_cycles   = 0;
  logic [KeyW-1:0] key_pool [PoolSize];

  always #4 clk_i = ~clk_i;

  proof_transposition_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ptt_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ends the run when the channels stay silent for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("proof_transposition_table: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high after a request unless a gap follows
  task automatic send_request(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                              input logic [PlyW-1:0] ply, input logic [MoveW-1:0] mv);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {mv, ply, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned     roll;
    logic [1:0]      cmd;
    logic [KeyW-1:0] key;
    logic [PlyW-1:0] ply;
    roll = $urandom_range(99);
    if (roll < 80) begin
      key = key_pool[$urandom_range(PoolSize - 1)];
    end else if (roll < 90) begin
      key = {$urandom, $urandom};
    end else begin
      // same slot, different tag
      key = key_pool[$urandom_range(PoolSize - 1)] ^ (64'd1 << $urandom_range(KeyW - 1, IdxW));
    end
    roll = $urandom_range(99);
    if (roll < 30)      cmd = CmdLookup;
    else if (roll < 60) cmd = CmdProven;
    else if (roll < 92) cmd = CmdDisproven;
    else                cmd = CmdSpare;
    roll = $urandom_range(99);
    if (roll < 65)      ply = PlyW'($urandom_range(15));
    else if (roll < 75) ply = '0;
    else                ply = PlyW'($urandom_range(255));
    send_request(cmd, key, ply, $urandom);
  endtask

  initial begin
    int unsigned     slot_pick [PoolSlots];
    logic [KeyW-1:0] key_a;
    logic [KeyW-1:0] key_b;
    foreach (slot_pick[i]) slot_pick[i] = $urandom_range(TableEntries - 1);
    foreach (key_pool[i]) begin
      key_pool[i]            = {$urandom, $urandom};
      key_pool[i][IdxW-1:0] = IdxW'(slot_pick[i % PoolSlots]);
    end
    key_a = key_pool[0];
    key_b = key_a ^ {1'b1, 63'd0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(CmdLookup, key_a, 8'd0, 32'd0);          // miss on an empty slot
    send_request(CmdProven, key_a, 8'd9, 32'hFFFF_FFFF);
    send_request(CmdLookup, key_a, 8'd0, 32'd0);
    send_request(CmdProven, key_a, 8'd12, 32'h1234_5678); // longer: ignored
    send_request(CmdProven, key_a, 8'd3, 32'h0F0F_0F0F);
    send_request(CmdProven, key_a, 8'd0, 32'hAAAA_5555);  // zero length drops the move
    send_request(CmdProven, key_a, 8'd5, 32'h5555_AAAA);
    send_request(CmdDisproven, key_a, 8'd7, 32'd0);
    send_request(CmdDisproven, key_a, 8'd4, 32'd0);       // shallower: ignored
    send_request(CmdDisproven, key_a, 8'd255, 32'd0);
    send_request(CmdLookup, key_b, 8'd0, 32'd0);          // foreign tag
    send_request(CmdSpare, key_a, 8'd17, 32'hFFFF_FFFF);
    send_request(CmdDisproven, key_b, 8'd0, 32'd0);       // evicts the old entry
    send_request(CmdLookup, key_a, 8'd0, 32'd0);
    send_request(CmdProven, '1, 8'd255, 32'hFFFF_FFFF);
    send_request(CmdProven, '0, 8'd255, 32'd0);
    send_request(CmdProven, '1, 8'd1, 32'h8000_0001);
    send_request(CmdLookup, '1, 8'd255, 32'hFFFF_FFFF);
    send_request(CmdLookup, '0, 8'd0, 32'd0);
    send_request(CmdSpare, '1, 8'd0, 32'd0);
    send_request(CmdDisproven, '0, 8'd255, 32'hFFFF_FFFF);
    send_request(CmdDisproven, '0, 8'd128, 32'd0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 18;
          recv_stall_pct = 54;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 18;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) send_random_request();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("proof_transposition_table: match");
    end else begin
      $display("proof_transposition_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_update.sv
hw/rtl/proof_transposition_table.sv
test/ptt_checker.sv
test/tb.sv
